// ===== hdl/kmd_pkg.sv =====
// Shared types, constants and the key layout for the keypad matrix debouncer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package kmd_pkg;

	// Matrix geometry.
	localparam int NUM_ROWS = 4;
	localparam int NUM_COLS = 4;
	localparam int ROW_W    = 2;
	localparam int COL_W    = 2;
	localparam int BITS_W   = NUM_ROWS * NUM_COLS;
	localparam int INDEX_W  = ROW_W + COL_W;
	localparam int CHAR_W   = 7;

	// Debounce limit register and tick counter.
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd20;
	localparam logic [LIMIT_W-1:0] TICKS_MAX   = 7'd127;

	// Row mode codes.
	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_PRESSING = 2'd1;
	localparam logic [1:0] MODE_PRESSED  = 2'd2;

	// One event found by a row lane on the current tick.
	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
		logic             rel;
	} kmd_event_t;

	// Key layout "123A" / "456B" / "789C" / "*0#D", indexed by row*4+col.
	localparam logic [CHAR_W-1:0] KEY_CHARS [BITS_W] = '{
		7'h31, 7'h32, 7'h33, 7'h41,
		7'h34, 7'h35, 7'h36, 7'h42,
		7'h37, 7'h38, 7'h39, 7'h43,
		7'h2A, 7'h30, 7'h23, 7'h44
	};

	function automatic logic [CHAR_W-1:0] key_char_of(input logic [INDEX_W-1:0] idx);
		return KEY_CHARS[idx];
	endfunction

endpackage

// ===== hdl/keypad_matrix_debouncer.sv =====
// Top level of the 4x4 keypad matrix debouncer: debounce register, row lanes and merge.
// Depends on kmd_pkg, kmd_row_lane and kmd_merge.
//
// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------------
// in        in_valid / in_ready    switch_closed[15:0]
// out       out_valid / out_ready  key_index[3:0], key_char[6:0], is_release, last
// cfg       cfg_valid / cfg_ready  cfg_data[6:0] (debounce limit)
//
// All four row lanes evaluate an accepted tick in parallel.
// Its events leave one per cycle while out_ready is high.
// The next tick is taken in the cycle the last event of the previous one leaves.
// The event buffer in the merge stage gates input this way; out_ready low holds input.
// Reset puts every row idle and the limit at 20; cfg_ready is always high.
`timescale 1ns / 1ps

module keypad_matrix_debouncer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kmd_pkg::BITS_W-1:0]         switch_closed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kmd_pkg::INDEX_W-1:0]        key_index,
	output logic [kmd_pkg::CHAR_W-1:0]         key_char,
	output logic                               is_release,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kmd_pkg::LIMIT_W-1:0]        cfg_data
);

	logic [kmd_pkg::LIMIT_W-1:0] limit_q;
	logic                        tick;
	kmd_pkg::kmd_event_t         ev [kmd_pkg::NUM_ROWS];

	// Debounce limit register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= kmd_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	assign tick = in_valid && in_ready;

	// One lane per keypad row.
	for (genvar r = 0; r < kmd_pkg::NUM_ROWS; r++) begin : g_row
		kmd_row_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (tick),
			.bits   (switch_closed[r*kmd_pkg::NUM_COLS +: kmd_pkg::NUM_COLS]),
			.limit  (limit_q),
			.ev     (ev[r])
		);
	end

	// Merge the row events into an ordered output stream.
	kmd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (tick),
		.ev         (ev),
		.space      (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_index  (key_index),
		.key_char   (key_char),
		.is_release (is_release),
		.last       (last)
	);

endmodule

// ===== hdl/kmd_row_lane.sv =====
// One row lane of the keypad debouncer: mode, latched column, tick count and level.
// Depends on kmd_pkg for mode codes, widths and the event type.
`timescale 1ns / 1ps

module kmd_row_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick,
	input  logic [kmd_pkg::NUM_COLS-1:0] bits,
	input  logic [kmd_pkg::LIMIT_W-1:0] limit,
	output kmd_pkg::kmd_event_t         ev
);

	logic [1:0]                  mode_q, mode_d;
	logic                        col_ok_q, col_ok_d;
	logic [kmd_pkg::COL_W-1:0]   col_q, col_d;
	logic [kmd_pkg::LIMIT_W-1:0] ticks_q, ticks_d;
	logic                        level_q;

	logic                        level;
	logic                        found;
	logic [kmd_pkg::COL_W-1:0]   low_col;
	logic [kmd_pkg::COL_W-1:0]   col_eff;
	logic                        col_eff_ok;
	logic                        held;
	logic [kmd_pkg::LIMIT_W-1:0] ticks_inc;

	assign level = |bits;

	// Lowest closed column of the row.
	always_comb begin
		found   = 1'b0;
		low_col = '0;
		for (int c = kmd_pkg::NUM_COLS - 1; c >= 0; c--) begin
			if (bits[c]) begin
				found   = 1'b1;
				low_col = c[kmd_pkg::COL_W-1:0];
			end
		end
	end

	assign col_eff_ok = col_ok_q | found;
	assign col_eff    = col_ok_q ? col_q : low_col;
	assign held       = bits[col_eff];
	assign ticks_inc  = (ticks_q == kmd_pkg::TICKS_MAX) ? ticks_q : ticks_q + 7'd1;

	// Next state of the row and the event it raises on this tick.
	always_comb begin
		mode_d   = mode_q;
		col_ok_d = col_ok_q;
		col_d    = col_q;
		ticks_d  = ticks_q;
		ev       = '0;
		ev.col   = col_eff;
		case (mode_q)
			kmd_pkg::MODE_IDLE: begin
				if (level && !level_q) begin
					mode_d   = kmd_pkg::MODE_PRESSING;
					ticks_d  = '0;
					col_ok_d = 1'b0;
				end
			end
			default: begin
				if (!col_eff_ok) begin
					// No column closed: the row drops back silently.
					mode_d   = kmd_pkg::MODE_IDLE;
					ticks_d  = '0;
					col_ok_d = 1'b0;
				end else begin
					col_ok_d = 1'b1;
					col_d    = col_eff;
					if (mode_q == kmd_pkg::MODE_PRESSING && held) begin
						ticks_d = ticks_inc;
						if (ticks_inc > limit) begin
							mode_d   = kmd_pkg::MODE_PRESSED;
							ev.valid = 1'b1;
						end
					end else begin
						ticks_d = '0;
						if (!held) begin
							ev.valid = 1'b1;
							ev.rel   = 1'b1;
							col_ok_d = 1'b0;
							mode_d   = kmd_pkg::MODE_IDLE;
						end
					end
				end
			end
		endcase
	end

	// Row state advances only on an accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= kmd_pkg::MODE_IDLE;
			col_ok_q <= 1'b0;
			col_q    <= '0;
			ticks_q  <= '0;
			level_q  <= 1'b0;
		end else if (tick) begin
			mode_q   <= mode_d;
			col_ok_q <= col_ok_d;
			col_q    <= col_d;
			ticks_q  <= ticks_d;
			level_q  <= level;
		end
	end

endmodule

// ===== hdl/kmd_merge.sv =====
// Merging stage: registers the events of all row lanes and hands them out in row order.
// Depends on kmd_pkg for the event type, widths and the key layout.
`timescale 1ns / 1ps

module kmd_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  kmd_pkg::kmd_event_t              ev [kmd_pkg::NUM_ROWS],
	output logic                             space,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kmd_pkg::INDEX_W-1:0]      key_index,
	output logic [kmd_pkg::CHAR_W-1:0]       key_char,
	output logic                             is_release,
	output logic                             last
);

	logic [kmd_pkg::NUM_ROWS-1:0] pend_q;
	logic [kmd_pkg::NUM_ROWS-1:0] pend_rest;
	kmd_pkg::kmd_event_t          ev_q [kmd_pkg::NUM_ROWS];
	logic [kmd_pkg::ROW_W-1:0]    sel_row;

	// Lowest pending row is the next request out.
	always_comb begin
		sel_row = '0;
		for (int r = kmd_pkg::NUM_ROWS - 1; r >= 0; r--) begin
			if (pend_q[r]) begin
				sel_row = r[kmd_pkg::ROW_W-1:0];
			end
		end
	end

	assign pend_rest  = pend_q & (pend_q - 4'd1);
	assign out_valid  = |pend_q;
	assign last       = (pend_rest == '0);
	assign key_index  = {sel_row, ev_q[sel_row].col};
	assign key_char   = kmd_pkg::key_char_of(key_index);
	assign is_release = ev_q[sel_row].rel;

	// A new tick may enter once the buffer empties in this cycle.
	assign space = !out_valid || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			for (int r = 0; r < kmd_pkg::NUM_ROWS; r++) begin
				pend_q[r] <= ev[r].valid;
			end
		end else if (out_valid && out_ready) begin
			pend_q <= pend_rest;
		end
	end

	// Event payload, held while requests drain.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int r = 0; r < kmd_pkg::NUM_ROWS; r++) begin
				ev_q[r] <= ev[r];
			end
		end
	end

endmodule

// ===== hdl/kmd_checker.sv =====
// Port-level checks for the keypad matrix debouncer, bound to the top level.
// Depends on kmd_pkg for widths and the key layout.
`timescale 1ns / 1ps

module kmd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [kmd_pkg::BITS_W-1:0]    switch_closed,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [kmd_pkg::INDEX_W-1:0]   key_index,
	input logic [kmd_pkg::CHAR_W-1:0]    key_char,
	input logic                          is_release,
	input logic                          last,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [kmd_pkg::LIMIT_W-1:0]   cfg_data
);

	// A stalled request keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_index) && $stable(is_release)
			&& $stable(last))
		else $error("output request changed while stalled");

	// A tick enters only when the previous tick's events are all gone.
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || (out_ready && last))
		else $error("tick accepted with events still pending");

	// Events of one tick keep coming until the last one.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("event burst ended without last");

	// Within one tick the rows come out in rising order.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> key_index[3:2] > $past(key_index[3:2]))
		else $error("events out of row order");

	// The character follows the key number.
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_char == kmd_pkg::key_char_of(key_index))
		else $error("key character does not match key index");

endmodule

bind keypad_matrix_debouncer kmd_checker u_kmd_checker (.*);
